// File: hdl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg: shared types and tables for the power stage supervisor
// Holds the state and action codes, the event codes and the fixed transition
// table of the supervisory sequencer, with the lookup function over it.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int EVT_W  = 5;
  localparam int ERR_W  = 5;
  localparam int ROW_CNT = 27;

  typedef enum logic [2:0] {
    ST_STANDBY   = 3'd0,
    ST_INIT      = 3'd1,
    ST_SOFTSTART = 3'd2,
    ST_SWEEP     = 3'd3,
    ST_RUNNING   = 3'd4,
    ST_RECOVERY  = 3'd5,
    ST_SOFTSTOP  = 3'd6,
    ST_HARDSTOP  = 3'd7
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE         = 4'd0,
    ACT_INIT         = 4'd1,
    ACT_SOFTSTART    = 4'd2,
    ACT_SWEEP        = 4'd3,
    ACT_RUN          = 4'd4,
    ACT_RECOVERY     = 4'd5,
    ACT_TUNE         = 4'd6,
    ACT_SOFTSTOP     = 4'd7,
    ACT_FAILSOFTSTOP = 4'd8,
    ACT_SHUTDOWN     = 4'd9,
    ACT_STANDBY      = 4'd10,
    ACT_RESTART      = 4'd11,
    ACT_RESET        = 4'd12
  } action_t;

  // Event codes. The input field can carry codes above the last one, which
  // simply match no row.
  localparam logic [EVT_W-1:0] EV_START          = 5'd0;
  localparam logic [EVT_W-1:0] EV_INIT_DONE      = 5'd1;
  localparam logic [EVT_W-1:0] EV_STOP           = 5'd2;
  localparam logic [EVT_W-1:0] EV_SOFTSTART_DONE = 5'd3;
  localparam logic [EVT_W-1:0] EV_HW_FAULT       = 5'd4;
  localparam logic [EVT_W-1:0] EV_RESO_FOUND     = 5'd5;
  localparam logic [EVT_W-1:0] EV_OVERPOWER      = 5'd6;
  localparam logic [EVT_W-1:0] EV_RESO_LOST      = 5'd7;
  localparam logic [EVT_W-1:0] EV_TARGET_POWER   = 5'd8;
  localparam logic [EVT_W-1:0] EV_OVERTEMP       = 5'd9;
  localparam logic [EVT_W-1:0] EV_UNDERVOLT      = 5'd10;
  localparam logic [EVT_W-1:0] EV_OVERCURRENT    = 5'd11;
  localparam logic [EVT_W-1:0] EV_SHORT          = 5'd12;
  localparam logic [EVT_W-1:0] EV_ARC            = 5'd13;
  localparam logic [EVT_W-1:0] EV_TUNE           = 5'd14;
  localparam logic [EVT_W-1:0] EV_GRID_FAULT     = 5'd15;
  localparam logic [EVT_W-1:0] EV_FAULT_CLEARED  = 5'd16;
  localparam logic [EVT_W-1:0] EV_SOFTSTOP_DONE  = 5'd17;

  typedef struct packed {
    state_t           from;
    logic [EVT_W-1:0] evt;
    action_t          act;
    state_t           to;
  } row_t;

  localparam row_t ROWS [ROW_CNT] = '{
    '{ST_STANDBY,   EV_START,          ACT_INIT,         ST_INIT},
    '{ST_INIT,      EV_INIT_DONE,      ACT_SOFTSTART,    ST_SOFTSTART},
    '{ST_INIT,      EV_STOP,           ACT_STANDBY,      ST_STANDBY},
    '{ST_SOFTSTART, EV_SOFTSTART_DONE, ACT_SWEEP,        ST_SWEEP},
    '{ST_SOFTSTART, EV_STOP,           ACT_SOFTSTOP,     ST_SOFTSTOP},
    '{ST_SOFTSTART, EV_HW_FAULT,       ACT_SHUTDOWN,     ST_HARDSTOP},
    '{ST_SWEEP,     EV_RESO_FOUND,     ACT_RUN,          ST_RUNNING},
    '{ST_SWEEP,     EV_OVERPOWER,      ACT_RUN,          ST_RUNNING},
    '{ST_SWEEP,     EV_RESO_LOST,      ACT_FAILSOFTSTOP, ST_SOFTSTOP},
    '{ST_SWEEP,     EV_STOP,           ACT_FAILSOFTSTOP, ST_SOFTSTOP},
    '{ST_SWEEP,     EV_HW_FAULT,       ACT_SHUTDOWN,     ST_HARDSTOP},
    '{ST_RUNNING,   EV_TARGET_POWER,   ACT_NONE,         ST_RUNNING},
    '{ST_RUNNING,   EV_STOP,           ACT_SOFTSTOP,     ST_SOFTSTOP},
    '{ST_RUNNING,   EV_RESO_LOST,      ACT_RECOVERY,     ST_RECOVERY},
    '{ST_RUNNING,   EV_OVERPOWER,      ACT_RECOVERY,     ST_RECOVERY},
    '{ST_RUNNING,   EV_OVERTEMP,       ACT_RECOVERY,     ST_RECOVERY},
    '{ST_RUNNING,   EV_UNDERVOLT,      ACT_RECOVERY,     ST_RECOVERY},
    '{ST_RUNNING,   EV_OVERCURRENT,    ACT_RECOVERY,     ST_RECOVERY},
    '{ST_RUNNING,   EV_SHORT,          ACT_SHUTDOWN,     ST_HARDSTOP},
    '{ST_RUNNING,   EV_ARC,            ACT_SHUTDOWN,     ST_HARDSTOP},
    '{ST_RECOVERY,  EV_TUNE,           ACT_TUNE,         ST_RUNNING},
    '{ST_RECOVERY,  EV_STOP,           ACT_SOFTSTOP,     ST_SOFTSTOP},
    '{ST_RECOVERY,  EV_HW_FAULT,       ACT_SHUTDOWN,     ST_HARDSTOP},
    '{ST_RECOVERY,  EV_GRID_FAULT,     ACT_SHUTDOWN,     ST_HARDSTOP},
    '{ST_RECOVERY,  EV_FAULT_CLEARED,  ACT_RESTART,      ST_SOFTSTART},
    '{ST_SOFTSTOP,  EV_SOFTSTOP_DONE,  ACT_STANDBY,      ST_STANDBY},
    '{ST_HARDSTOP,  EV_FAULT_CLEARED,  ACT_RESET,        ST_STANDBY}
  };

  typedef struct packed {
    logic    hit;
    action_t act;
    state_t  to;
  } lookup_t;

  // Each row is compared on its own; the keys are unique, so at most one hits.
  function automatic lookup_t table_lookup(state_t st, logic [EVT_W-1:0] evt);
    lookup_t res;
    res = '{hit: 1'b0, act: ACT_NONE, to: st};
    for (int i = 0; i < ROW_CNT; i++) begin
      if (ROWS[i].from == st && ROWS[i].evt == evt) begin
        res.hit = 1'b1;
        res.act = ROWS[i].act;
        res.to  = ROWS[i].to;
      end
    end
    return res;
  endfunction

  // One result transaction, in output bus order from the highest bit down.
  typedef struct packed {
    logic [ERR_W-1:0] error_now;
    state_t           state_now;
    action_t          action_code;
    logic             accepted;
    logic             matched;
  } result_t;

endpackage

// File: hdl/power_stage_supervisor_fsm.sv
// ----------------------------------------------------------------------------
// power_stage_supervisor_fsm: supervisory sequencer for a resonant power stage
// Table-driven eight-state machine that reports the action for each event and
// advances, holds or latches an error depending on whether the action worked.
// ----------------------------------------------------------------------------
// Each input transaction carries an event code and a flag telling whether the
// side action of the matching transition succeeded. The block looks the event
// up in the fixed 27-row transition table for the current state in the same
// cycle the transaction is accepted, updates the state and error registers at
// that edge, and registers one result transaction at that edge as well. The
// sustained rate is one event per clock cycle while the output does not stall;
// the output register sits after the table decode. A second,
// skid register lets one more event be accepted while a result waits on a
// stalled output, so input ready only drops when both registers are full.
// An event with no row for the current state returns matched, accepted and
// action code zero and changes nothing. A failed action holds the state and
// latches one plus the event code as the error; only reset clears it. The
// row for a running stage reaching target power has no side action and always
// succeeds, whatever the flag says.
module power_stage_supervisor_fsm
  import pss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [4:0] event_code, [5] action_ok, [7:6] zero
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] matched, [1] accepted, [5:2] action_code,
                                  // [8:6] state_now, [13:9] error_now, [15:14] zero
);

  logic [EVT_W-1:0] in_evt;
  logic             in_ok;
  logic             in_fire;
  logic             out_fire;

  state_t           state_r, state_nxt;
  logic [ERR_W-1:0] error_r, error_nxt;
  lookup_t          hit;
  logic             ok;
  result_t          res;

  result_t          out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          skid_r, skid_nxt;
  logic             skid_valid_r, skid_valid_nxt;

  assign in_evt   = in_tdata[EVT_W-1:0];
  assign in_ok    = in_tdata[EVT_W];
  assign in_tready = !skid_valid_r;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_valid_r && out_tready;

  // Table decode and next state. The "none" action always succeeds.
  always_comb begin
    hit       = table_lookup(state_r, in_evt);
    ok        = (hit.act == ACT_NONE) ? 1'b1 : in_ok;
    state_nxt = state_r;
    error_nxt = error_r;
    if (in_fire && hit.hit) begin
      if (ok) begin
        state_nxt = hit.to;
      end else begin
        error_nxt = in_evt + ERR_W'(1);
      end
    end
    res.matched     = hit.hit;
    res.accepted    = hit.hit && ok;
    res.action_code = hit.act;
    res.state_now   = state_nxt;
    res.error_now   = error_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_STANDBY;
      error_r <= '0;
    end else begin
      state_r <= state_nxt;
      error_r <= error_nxt;
    end
  end

  // Output register with a skid stage. A new result goes to the skid register
  // only when the output register is full and stalled.
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (in_fire) begin
      if (out_valid_r && !out_tready) begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end else begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_nxt        = skid_r;
      out_valid_nxt  = skid_valid_r;
      skid_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r};

  // The skid register only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register valid while output register empty");

  // State and error move only on an accepted input transaction.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> ($stable(state_r) && $stable(error_r)))
    else $error("state or error changed without an input transaction");

  // A result that advanced the state must have matched a row.
  a_accept_matched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.accepted || out_r.matched))
    else $error("accepted result without a matching row");

  // A rejected action leaves the state where it was.
  a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && hit.hit && !ok) |=> $stable(state_r))
    else $error("state advanced on a failed action");

endmodule

// File: bench/power_stage_supervisor_checker.sv
// ----------------------------------------------------------------------------
// power_stage_supervisor_checker: result checker for the supervisor sequencer
// Watches both streams. It works out the expected result of every accepted
// event and compares each returned result against the oldest one still owed.
// ----------------------------------------------------------------------------
module power_stage_supervisor_checker
  import pss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          table_hits,
  output int          refused,
  output logic [7:0]  states_seen
);

  result_t          owed_results [$];
  state_t           seq_state;
  logic [ERR_W-1:0] seq_error;
  result_t          want;
  result_t          got;
  int               lines_printed;

  task automatic flag_error(input string msg);
    if (lines_printed < 40) begin
      $display("checker: %0t: %s", $time, msg);
    end
    lines_printed++;
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] seen,
                             input logic [15:0] owed);
    if (seen !== owed) begin
      flag_error($sformatf("%s is %0h, expected %0h", name, seen, owed));
    end
  endtask

  // One step of the sequencer: look up the transition for this state and
  // event, then decide from the action flag whether the state advances.
  function automatic result_t sequence_event(input state_t st,
                                             input logic [ERR_W-1:0] err,
                                             input logic [EVT_W-1:0] evt,
                                             input logic ok);
    result_t res;
    logic    hit;
    action_t act;
    state_t  dest;
    hit  = 1'b1;
    act  = ACT_NONE;
    dest = st;
    case (st)
      ST_STANDBY: begin
        if (evt == EV_START) begin
          act = ACT_INIT; dest = ST_INIT;
        end else begin
          hit = 1'b0;
        end
      end
      ST_INIT: begin
        case (evt)
          EV_INIT_DONE: begin act = ACT_SOFTSTART; dest = ST_SOFTSTART; end
          EV_STOP:      begin act = ACT_STANDBY;   dest = ST_STANDBY;   end
          default:      hit = 1'b0;
        endcase
      end
      ST_SOFTSTART: begin
        case (evt)
          EV_SOFTSTART_DONE: begin act = ACT_SWEEP;    dest = ST_SWEEP;    end
          EV_STOP:           begin act = ACT_SOFTSTOP; dest = ST_SOFTSTOP; end
          EV_HW_FAULT:       begin act = ACT_SHUTDOWN; dest = ST_HARDSTOP; end
          default:           hit = 1'b0;
        endcase
      end
      ST_SWEEP: begin
        case (evt)
          EV_RESO_FOUND, EV_OVERPOWER: begin act = ACT_RUN; dest = ST_RUNNING; end
          EV_RESO_LOST, EV_STOP: begin
            act = ACT_FAILSOFTSTOP; dest = ST_SOFTSTOP;
          end
          EV_HW_FAULT: begin act = ACT_SHUTDOWN; dest = ST_HARDSTOP; end
          default:     hit = 1'b0;
        endcase
      end
      ST_RUNNING: begin
        case (evt)
          EV_TARGET_POWER: begin act = ACT_NONE;     dest = ST_RUNNING;  end
          EV_STOP:         begin act = ACT_SOFTSTOP; dest = ST_SOFTSTOP; end
          EV_RESO_LOST, EV_OVERPOWER, EV_OVERTEMP, EV_UNDERVOLT, EV_OVERCURRENT: begin
            act = ACT_RECOVERY; dest = ST_RECOVERY;
          end
          EV_SHORT, EV_ARC: begin act = ACT_SHUTDOWN; dest = ST_HARDSTOP; end
          default:          hit = 1'b0;
        endcase
      end
      ST_RECOVERY: begin
        case (evt)
          EV_TUNE:          begin act = ACT_TUNE;     dest = ST_RUNNING;   end
          EV_STOP:          begin act = ACT_SOFTSTOP; dest = ST_SOFTSTOP;  end
          EV_HW_FAULT, EV_GRID_FAULT: begin
            act = ACT_SHUTDOWN; dest = ST_HARDSTOP;
          end
          EV_FAULT_CLEARED: begin act = ACT_RESTART;  dest = ST_SOFTSTART; end
          default:          hit = 1'b0;
        endcase
      end
      ST_SOFTSTOP: begin
        if (evt == EV_SOFTSTOP_DONE) begin
          act = ACT_STANDBY; dest = ST_STANDBY;
        end else begin
          hit = 1'b0;
        end
      end
      default: begin
        if (evt == EV_FAULT_CLEARED) begin
          act = ACT_RESET; dest = ST_STANDBY;
        end else begin
          hit = 1'b0;
        end
      end
    endcase
    // The target power row has no side action, so it cannot fail.
    res.matched     = hit;
    res.accepted    = hit && (ok || act == ACT_NONE);
    res.action_code = act;
    res.state_now   = res.accepted ? dest : st;
    res.error_now   = (hit && !res.accepted) ? ERR_W'(evt + 1'b1) : err;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_results.delete();
      seq_state    = ST_STANDBY;
      seq_error    = '0;
      fail_count   = 0;
      results_seen = 0;
      table_hits   = 0;
      refused      = 0;
      states_seen  = 8'b0000_0001;
      lines_printed = 0;
    end else begin
      // Results go first: a result can never belong to an event taken in
      // the same cycle.
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[13:0]);
        results_seen++;
        if (owed_results.size() == 0) begin
          flag_error($sformatf("result %h arrived with no event outstanding", out_tdata));
        end else begin
          want = owed_results.pop_front();
          check_field("matched", 16'(got.matched), 16'(want.matched));
          check_field("accepted", 16'(got.accepted), 16'(want.accepted));
          check_field("action_code", 16'(got.action_code), 16'(want.action_code));
          check_field("state_now", 16'(got.state_now), 16'(want.state_now));
          check_field("error_now", 16'(got.error_now), 16'(want.error_now));
          check_field("padding", 16'(out_tdata[15:14]), 16'(2'b00));
        end
      end
      if (in_tvalid && in_tready) begin
        want = sequence_event(seq_state, seq_error, in_tdata[4:0], in_tdata[5]);
        owed_results.push_back(want);
        seq_state = want.state_now;
        seq_error = want.error_now;
        table_hits += int'(want.matched);
        refused    += int'(want.matched && !want.accepted);
        states_seen[want.state_now] = 1'b1;
      end
    end
    pending <= owed_results.size();
  end

endmodule

// File: bench/tb_power_stage_supervisor_fsm.sv
// ----------------------------------------------------------------------------
// tb_power_stage_supervisor_fsm: stream testbench for the supervisor sequencer
// Drives a directed walk through every state, then random
// event streams steered along legal paths with noise mixed in, under random
// stalls on both sides. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_power_stage_supervisor_fsm
  import pss_pkg::*;
();

  localparam int RANDOM_EVENTS  = 1600;
  localparam int HOLD_LEN       = 40;   // length of the forced receiver hold-off
  localparam int WATCHDOG_LIMIT = 600;  // cycles without any transaction
  localparam int DRAIN_CYCLES   = 4;    // extra wait after the checker has drained

  // An event code well beyond the table, with every bit set.
  localparam logic [EVT_W-1:0] EV_ALL_ONES = '1;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  int          fail_count;
  int          pending;
  int          results_seen;
  int          table_hits;
  int          refused;
  logic [7:0]  states_seen;

  // Handshake between the stimulus and the receiver process: the stimulus
  // counts requested hold-offs, the receiver counts the ones it has done.
  int          hold_req;
  bit          rx_steady;
  int          holds_done;
  int          events_sent;
  int          idle_cycles;

  // The stimulus keeps track of where its walk should be, so that it can
  // pick events that the current state actually has a transition for.
  state_t      walk_state;

  power_stage_supervisor_fsm dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  power_stage_supervisor_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .table_hits   (table_hits),
    .refused      (refused),
    .states_seen  (states_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths for both sides: mostly none, often short, now and then long.
  function automatic int short_or_long();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Offers one event and waits for its transaction. The valid stays high on
  // return, so a following event can go out back to back without a bubble.
  task automatic send_event(input logic [EVT_W-1:0] evt, input logic ok);
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, ok, evt};
    do @(posedge clk); while (in_tready !== 1'b1);
    events_sent++;
    for (int i = 0; i < ROW_CNT; i++) begin
      if (ROWS[i].from == walk_state && ROWS[i].evt == evt &&
          (ok || ROWS[i].act == ACT_NONE)) begin
        walk_state = ROWS[i].to;
      end
    end
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stops offering and waits until the checker owes nothing. The count it
  // reports is registered, so the task waits on the clock before its first look.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver: random ready and stall runs, a steady mode with no stalls at
  // all, and a long hold-off on request so that the block backs up.
  initial begin
    int ready_left;
    int stall_left;
    out_tready <= 1'b0;
    holds_done = 0;
    ready_left = 0;
    stall_left = 0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (holds_done < hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        holds_done++;
      end else begin
        if (ready_left == 0 && stall_left == 0) begin
          ready_left = $urandom_range(1, 24);
          stall_left = short_or_long();
        end
        if (rx_steady || ready_left > 0) begin
          out_tready <= 1'b1;
          if (ready_left > 0) ready_left--;
        end else begin
          out_tready <= 1'b0;
          stall_left--;
        end
        @(posedge clk);
      end
    end
  end

  // Watchdog: a run that stops moving for too long is a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("tb_power_stage_supervisor_fsm: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [EVT_W-1:0] options [$];
    logic [EVT_W-1:0] evt;
    logic             ok;
    int               r;
    int               burst_left;

    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    rst_n      <= 1'b0;
    hold_req    = 0;
    rx_steady   = 1'b0;
    events_sent = 0;
    walk_state  = ST_STANDBY;
    burst_left  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk, back to back. It visits every state, takes both sides
    // of the action flag, and covers events with no transition, including
    // codes past the end of the table.
    send_event(EV_ALL_ONES, 1'b1);          // no transition from standby
    send_event(EV_START, 1'b0);             // failed action latches an error
    send_event(EV_START, 1'b1);
    send_event(EV_INIT_DONE, 1'b1);
    send_event(EV_SOFTSTART_DONE, 1'b1);
    send_event(EV_RESO_FOUND, 1'b1);
    send_event(EV_TARGET_POWER, 1'b0);      // no side action: flag is ignored
    send_event(EV_ARC, 1'b0);               // later failure overwrites the error
    send_event(EV_RESO_LOST, 1'b1);
    send_event(EV_TUNE, 1'b1);
    send_event(EV_OVERCURRENT, 1'b1);
    send_event(EV_FAULT_CLEARED, 1'b1);
    send_event(EV_HW_FAULT, 1'b1);
    send_event(EV_SOFTSTOP_DONE, 1'b1);     // not a hard stop transition
    send_event(EV_FAULT_CLEARED, 1'b0);
    send_event(EV_FAULT_CLEARED, 1'b1);
    send_event(EV_START, 1'b1);
    send_event(EV_STOP, 1'b1);
    send_event(EV_START, 1'b1);
    send_event(EV_INIT_DONE, 1'b1);
    send_event(EV_SOFTSTART_DONE, 1'b1);
    send_event(EV_RESO_LOST, 1'b0);
    send_event(EV_STOP, 1'b1);
    send_event(EV_SOFTSTOP_DONE, 1'b0);     // largest error code
    send_event(EV_SOFTSTOP_DONE, 1'b1);
    wait_drained();

    // Random part. Most events are legal for the state the walk is in, with
    // the action mostly succeeding, so long paths through the table happen.
    // The rest is any table event with any flag, or a code past the table.
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n == 400) begin
        // Receiver holds off while the sender keeps offering: the output
        // and skid registers fill and the input ready must drop.
        hold_req++;
        burst_left = 30;
      end
      if (n == 800 || n == 1200) wait_drained();
      if (n == 1000) rx_steady = 1'b1;
      if (n == 1100) rx_steady = 1'b0;

      r = $urandom_range(0, 99);
      if (r < 70) begin
        options.delete();
        for (int i = 0; i < ROW_CNT; i++) begin
          if (ROWS[i].from == walk_state) options.push_back(ROWS[i].evt);
        end
        evt = options[$urandom_range(0, options.size() - 1)];
        ok  = ($urandom_range(0, 99) < 85);
      end else if (r < 90) begin
        evt = EVT_W'($urandom_range(EV_START, EV_SOFTSTOP_DONE));
        ok  = 1'($urandom_range(0, 1));
      end else begin
        evt = EVT_W'($urandom_range(EV_SOFTSTOP_DONE + 1, EV_ALL_ONES));
        ok  = 1'($urandom_range(0, 1));
      end
      send_event(evt, ok);

      // No gaps during the pressure burst or the steady stretch.
      if (burst_left > 0) begin
        burst_left--;
      end else if (!rx_steady) begin
        idle_gap(short_or_long());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d events and %0d results: %0d table hits, %0d refused actions",
             events_sent, results_seen, table_hits, refused);
    $display("states reached %b, receiver hold-offs %0d", states_seen, holds_done);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_power_stage_supervisor_fsm: done, clean");
    end else begin
      $display("tb_power_stage_supervisor_fsm: done, errors");
    end
    $finish;
  end

endmodule
